>>> design/lbpt_pkg.sv
`timescale 1ns / 1ps

package lbpt_pkg;

  // store geometry
  localparam int MAX_LEDS      = 512;
  localparam int STRINGS       = 6;
  localparam int SLOTS_PER_LED = 3 * 8;
  localparam int SLOT_COUNT    = MAX_LEDS * SLOTS_PER_LED;
  localparam int ROW_W         = SLOTS_PER_LED * STRINGS;
  localparam int ROW_AW        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int STR_W         = (STRINGS > 1) ? $clog2(STRINGS) : 1;
  localparam int POS_W         = 5;

  // field widths
  localparam int REQ_W      = 2;
  localparam int LED_W      = 16;
  localparam int SEL_W      = 8;
  localparam int CHAN_W     = 8;
  localparam int SLOT_W     = 14;
  localparam int PAT_W      = STRINGS;
  localparam int GAIN_W     = 8;
  localparam int CNT_W      = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 10;

  // slot / 24 as (slot >> 3) * 683 >> 11, exact for every 14-bit slot
  localparam int DIV_IN_W    = SLOT_W - 3;
  localparam int RECIP       = 683;
  localparam int RECIP_W     = 10;
  localparam int RECIP_SHIFT = 11;
  localparam int QUO_W       = DIV_IN_W + RECIP_W - RECIP_SHIFT;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE_RGB = 2'd0,
    REQ_WRITE_CMY = 2'd1,
    REQ_READ_SLOT = 2'd2,
    REQ_CLEAR_ALL = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_GAIN   = 8'd0,
    REG_GREEN_GAIN = 8'd1,
    REG_BLUE_GAIN  = 8'd2,
    REG_LED_COUNT  = 8'd3
  } reg_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_RUN,
    BK_CLEAR
  } bk_state_e;

  typedef struct packed {
    op_e               op;
    logic [ROW_AW-1:0] row;
    logic [STR_W-1:0]  str;
    logic [POS_W-1:0]  pos;
    logic              oor;
    logic              last;
    logic [CHAN_W-1:0] grn;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] blu;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } stat_t;

endpackage

>>> design/lbpt_if.sv
`timescale 1ns / 1ps

interface lbpt_in_if;
  import lbpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [LED_W-1:0]  led_index;
  logic [SEL_W-1:0]  string_sel;
  logic [CHAN_W-1:0] chan_a;
  logic [CHAN_W-1:0] chan_b;
  logic [CHAN_W-1:0] chan_c;
  logic [SLOT_W-1:0] slot_index;

  modport source (
    output valid, req_type, led_index, string_sel, chan_a, chan_b, chan_c, slot_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, led_index, string_sel, chan_a, chan_b, chan_c, slot_index,
    output ready
  );
endinterface

interface lbpt_out_if;
  import lbpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [PAT_W-1:0] pattern;
  logic             last_slot;

  modport source (output valid, pattern, last_slot, input ready);
  modport sink (input valid, pattern, last_slot, output ready);
endinterface

interface lbpt_cfg_if;
  import lbpt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

>>> design/led_bitplane_pixel_transposer.sv
// a slot read goes through the command queue, row read register and output register
// throughput: one word per cycle for pixel writes and slot reads unless output stalls
// a clear-all word holds the command queue while every row is cleared (one row per cycle)
// reset: rst_ni async active low; afterwards a pass over every row fills the store with
// all ones while input ready stays low; config writes are taken throughout
`timescale 1ns / 1ps

module led_bitplane_pixel_transposer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbpt_in_if.sink    in_chan_i,
  lbpt_cfg_if.sink   cfg_chan_i,
  lbpt_out_if.source out_chan_o
);
  import lbpt_pkg::*;

  // front to queue
  logic  q_push;
  cmd_t  q_cmd;
  logic  q_full;

  // queue to back
  logic  q_pop;
  logic  q_empty;
  cmd_t  q_head;

  // back status seen by the front (store fill pass after reset)
  stat_t stat;

  // front: owns the gain and length registers, classifies each word, scales
  // the colours and turns a slot number into row and bit position
  lbpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan_i),
    .cfg_chan_i (cfg_chan_i),
    .stat_i     (stat),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  // two-entry command queue, lets front and back stall independently
  lbpt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // back: bit-plane store with one 24-slot row per led, masked row writes,
  // registered row reads, clear walker and output register
  lbpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_chan_o (out_chan_o),
    .stat_o     (stat)
  );

endmodule

>>> design/lbpt_front.sv
`timescale 1ns / 1ps

module lbpt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  lbpt_in_if.sink        in_chan_i,
  lbpt_cfg_if.sink       cfg_chan_i,
  input  lbpt_pkg::stat_t stat_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output lbpt_pkg::cmd_t q_cmd_o
);
  import lbpt_pkg::*;

  logic [GAIN_W-1:0] red_gain_q, green_gain_q, blue_gain_q;
  logic [CNT_W-1:0]  led_count_q;
  logic [CNT_W-1:0]  cnt_wr;

  req_e                req;
  logic [CHAN_W-1:0]   a_eff, b_eff, c_eff;
  logic [CHAN_W:0]     a_inc, b_inc, c_inc;
  logic [CHAN_W+GAIN_W:0] prod_r, prod_g, prod_b;
  logic [DIV_IN_W-1:0] div_in;
  logic [DIV_IN_W+RECIP_W-1:0] div_prod;
  logic [QUO_W-1:0]    quo;
  logic [SLOT_W-1:0]   quo24;
  logic [SLOT_W:0]     frame_len;

  // register file, always ready; values apply to words accepted afterwards
  assign cfg_chan_i.ready = 1'b1;

  always_comb begin
    cnt_wr = cfg_chan_i.wr_data[CNT_W-1:0];
    if (cnt_wr == '0) begin
      cnt_wr = CNT_W'(1);
    end else if (cnt_wr > CNT_W'(MAX_LEDS)) begin
      cnt_wr = CNT_W'(MAX_LEDS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_gain_q   <= '0;
      green_gain_q <= '0;
      blue_gain_q  <= '0;
      led_count_q  <= CNT_W'(MAX_LEDS);
    end else if (cfg_chan_i.valid) begin
      case (reg_e'(cfg_chan_i.reg_index))
        REG_RED_GAIN:   red_gain_q   <= cfg_chan_i.wr_data[GAIN_W-1:0];
        REG_GREEN_GAIN: green_gain_q <= cfg_chan_i.wr_data[GAIN_W-1:0];
        REG_BLUE_GAIN:  blue_gain_q  <= cfg_chan_i.wr_data[GAIN_W-1:0];
        REG_LED_COUNT:  led_count_q  <= cnt_wr;
        default: ;
      endcase
    end
  end

  assign in_chan_i.ready = !q_full_i && !stat_i.init_busy;
  assign q_push_o        = in_chan_i.valid && in_chan_i.ready;

  always_comb begin
    req   = req_e'(in_chan_i.req_type);
    a_eff = (req == REQ_WRITE_CMY) ? ~in_chan_i.chan_a : in_chan_i.chan_a;
    b_eff = (req == REQ_WRITE_CMY) ? ~in_chan_i.chan_b : in_chan_i.chan_b;
    c_eff = (req == REQ_WRITE_CMY) ? ~in_chan_i.chan_c : in_chan_i.chan_c;
    // c + (c > 0), then gain; products land in the queue register
    a_inc  = {1'b0, a_eff} + (CHAN_W+1)'(a_eff != '0);
    b_inc  = {1'b0, b_eff} + (CHAN_W+1)'(b_eff != '0);
    c_inc  = {1'b0, c_eff} + (CHAN_W+1)'(c_eff != '0);
    prod_r = (CHAN_W+GAIN_W+1)'(a_inc) * (CHAN_W+GAIN_W+1)'(red_gain_q);
    prod_g = (CHAN_W+GAIN_W+1)'(b_inc) * (CHAN_W+GAIN_W+1)'(green_gain_q);
    prod_b = (CHAN_W+GAIN_W+1)'(c_inc) * (CHAN_W+GAIN_W+1)'(blue_gain_q);

    // slot to row and bit position
    div_in    = in_chan_i.slot_index[SLOT_W-1:3];
    div_prod  = (DIV_IN_W+RECIP_W)'(div_in) * (DIV_IN_W+RECIP_W)'(RECIP);
    quo       = div_prod[DIV_IN_W+RECIP_W-1:RECIP_SHIFT];
    quo24     = SLOT_W'({quo, 4'b0}) + SLOT_W'({quo, 3'b0});
    frame_len = (SLOT_W+1)'(led_count_q) * (SLOT_W+1)'(SLOTS_PER_LED);

    q_cmd_o      = '0;
    q_cmd_o.grn  = prod_g[CHAN_W+GAIN_W-1:GAIN_W];
    q_cmd_o.red  = prod_r[CHAN_W+GAIN_W-1:GAIN_W];
    q_cmd_o.blu  = prod_b[CHAN_W+GAIN_W-1:GAIN_W];
    q_cmd_o.str  = (in_chan_i.string_sel > SEL_W'(STRINGS - 1)) ? STR_W'(STRINGS - 1)
                                                               : in_chan_i.string_sel[STR_W-1:0];
    q_cmd_o.oor  = {1'b0, in_chan_i.slot_index} >= (SLOT_W+1)'(SLOT_COUNT);
    q_cmd_o.last = {1'b0, in_chan_i.slot_index} == (frame_len - (SLOT_W+1)'(1));
    q_cmd_o.pos  = POS_W'(in_chan_i.slot_index - quo24);

    case (req)
      REQ_WRITE_RGB, REQ_WRITE_CMY: begin
        q_cmd_o.op  = OP_WRITE;
        q_cmd_o.row = (in_chan_i.led_index >= LED_W'(MAX_LEDS)) ? ROW_AW'(MAX_LEDS - 1)
                                                              : in_chan_i.led_index[ROW_AW-1:0];
      end
      REQ_READ_SLOT: begin
        q_cmd_o.op  = OP_READ;
        q_cmd_o.row = quo[ROW_AW-1:0];
      end
      default: begin
        q_cmd_o.op  = OP_CLEAR;
        q_cmd_o.row = '0;
      end
    endcase
  end

endmodule

>>> design/lbpt_fifo.sv
`timescale 1ns / 1ps

module lbpt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lbpt_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lbpt_pkg::cmd_t head_o
);
  import lbpt_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> design/lbpt_back.sv
`timescale 1ns / 1ps

module lbpt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  lbpt_pkg::cmd_t  q_head_i,
  output logic            q_pop_o,
  lbpt_out_if.source      out_chan_o,
  output lbpt_pkg::stat_t stat_o
);
  import lbpt_pkg::*;

  // one row per led: slot p, string k at bit p*STRINGS+k
  logic [ROW_W-1:0] plane_mem [MAX_LEDS];

  bk_state_e         state_q, state_d;
  logic [ROW_AW-1:0] clr_row_q, clr_row_d;
  logic              clr_end;

  logic              mem_we, mem_re;
  logic [ROW_AW-1:0] mem_addr;
  logic [ROW_W-1:0]  wmask, wdata;
  logic [ROW_W-1:0]  rdata_q;
  logic [SLOTS_PER_LED-1:0] word;

  logic              rd_pend_q, rd_pend_d;
  logic [POS_W-1:0]  rd_pos_q;
  logic              rd_oor_q, rd_last_q;
  logic              rd_move;
  logic [PAT_W-1:0]  rd_pat;

  logic              out_valid_q, out_valid_d;
  logic [PAT_W-1:0]  out_pat_q;
  logic              out_last_q;

  assign clr_end = (clr_row_q == ROW_AW'(MAX_LEDS - 1));
  assign rd_move = rd_pend_q && (!out_valid_q || out_chan_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_INIT, BK_CLEAR: begin
        if (clr_end) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (q_pop_o && q_head_i.op == OP_CLEAR) begin
          state_d = BK_CLEAR;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = q_head_i.row;
    wmask     = '0;
    wdata     = '0;
    clr_row_d = '0;
    word      = ~{q_head_i.grn, q_head_i.red, q_head_i.blu};
    stat_o.init_busy = (state_q == BK_INIT);
    case (state_q)
      BK_INIT, BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_row_q;
        wmask     = '1;
        wdata     = '1;
        clr_row_d = clr_end ? '0 : clr_row_q + ROW_AW'(1);
      end
      BK_RUN: begin
        q_pop_o = !q_empty_i &&
                  (q_head_i.op != OP_READ || !rd_pend_q || rd_move);
        if (q_pop_o && q_head_i.op == OP_WRITE) begin
          mem_we = 1'b1;
          for (int p = 0; p < SLOTS_PER_LED; p++) begin
            for (int k = 0; k < STRINGS; k++) begin
              if (q_head_i.str == STR_W'(k)) begin
                wmask[p*STRINGS+k] = 1'b1;
                wdata[p*STRINGS+k] = word[SLOTS_PER_LED-1-p];
              end
            end
          end
        end
        if (q_pop_o && q_head_i.op == OP_READ) begin
          mem_re = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < ROW_W; b++) begin
        if (wmask[b]) begin
          plane_mem[mem_addr][b] <= wdata[b];
        end
      end
    end
    if (mem_re) begin
      rdata_q <= plane_mem[mem_addr];
    end
  end

  always_comb begin
    rd_pat = '1;
    for (int p = 0; p < SLOTS_PER_LED; p++) begin
      if (rd_pos_q == POS_W'(p)) begin
        rd_pat = rdata_q[p*STRINGS +: STRINGS];
      end
    end
    if (rd_oor_q) begin
      rd_pat = '1;
    end
    rd_pend_d   = mem_re ? 1'b1 : (rd_move ? 1'b0 : rd_pend_q);
    out_valid_d = rd_move ? 1'b1 : (out_chan_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_pos_q  <= q_head_i.pos;
      rd_oor_q  <= q_head_i.oor;
      rd_last_q <= q_head_i.last;
    end
    if (rd_move) begin
      out_pat_q  <= rd_pat;
      out_last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_INIT;
      clr_row_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_chan_o.valid     = out_valid_q;
  assign out_chan_o.pattern   = out_pat_q;
  assign out_chan_o.last_slot = out_last_q;

endmodule

>>> design/lbpt_checker.sv
`timescale 1ns / 1ps

module lbpt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lbpt_pkg::PAT_W-1:0] out_pattern_i,
  input logic                       out_last_i
);
  import lbpt_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pattern_i) && $stable(out_last_i))
    else $error("stalled result word changed");

  // the store fill pass after reset keeps the input closed
  a_init_closed: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_i)
    else $error("input ready during store fill pass");

  // no result word straight out of reset
  a_rst_no_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result word right after reset");

  // a word offered while ready stays low keeps being offered
  a_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i || $past(in_ready_i))
    else $error("input word dropped while stalled");

endmodule

bind led_bitplane_pixel_transposer lbpt_checker u_lbpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_chan_i.valid),
  .in_ready_i    (in_chan_i.ready),
  .out_valid_i   (out_chan_o.valid),
  .out_ready_i   (out_chan_o.ready),
  .out_pattern_i (out_chan_o.pattern),
  .out_last_i    (out_chan_o.last_slot)
);
